[rtl/core/scba_pkg.sv]
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, codes, control store and size class table for the
// size class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

  // default configuration
  localparam int DEF_CHUNK_BYTES   = 16 * 1024;
  localparam int DEF_MAX_CHUNKS    = 16;
  localparam int DEF_LARGEST_CLASS = 640;
  localparam int DEF_CLASS_COUNT   = 14;

  // number of entries in the size class table
  localparam int TABLE_LEN = 14;

  // transaction field types
  typedef logic [1:0]  op_t;
  typedef logic [15:0] size_t;
  typedef logic [17:0] addr_t;
  typedef logic [1:0]  stat_t;

  // operation codes
  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_FREE  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  // status codes
  localparam stat_t ST_OK        = 2'd0;
  localparam stat_t ST_ZERO      = 2'd1;
  localparam stat_t ST_OVERSIZE  = 2'd2;
  localparam stat_t ST_EXHAUSTED = 2'd3;

  // sequencer step addresses
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t S_IDLE     = 3'd0;
  localparam step_t S_DISPATCH = 3'd1;
  localparam step_t S_POP      = 3'd2;
  localparam step_t S_CARVE    = 3'd3;
  localparam step_t S_CDONE    = 3'd4;
  localparam step_t S_EMIT     = 3'd5;

  // datapath action codes
  localparam int ACT_W = 3;
  typedef logic [ACT_W-1:0] act_t;
  localparam act_t ACT_NOP    = 3'd0;
  localparam act_t ACT_DECODE = 3'd1;
  localparam act_t ACT_POP    = 3'd2;
  localparam act_t ACT_CSTEP  = 3'd3;
  localparam act_t ACT_CDONE  = 3'd4;
  localparam act_t ACT_EMIT   = 3'd5;

  // jump condition codes
  localparam int COND_W = 3;
  typedef logic [COND_W-1:0] cond_t;
  localparam cond_t C_INPUT  = 3'd0;  // go to target once a transaction is taken
  localparam cond_t C_DECODE = 3'd1;  // multiway branch on the decoded request
  localparam cond_t C_GOTO   = 3'd2;  // unconditional jump
  localparam cond_t C_CARVE  = 3'd3;  // stay while more blocks remain to link
  localparam cond_t C_OUTPUT = 3'd4;  // stay until the result register is free

  // decoded request routes
  localparam int ROUTE_W = 2;
  typedef logic [ROUTE_W-1:0] route_t;
  localparam route_t RT_DONE  = 2'd0;
  localparam route_t RT_POP   = 2'd1;
  localparam route_t RT_CARVE = 2'd2;

  // one control store word
  typedef struct packed {
    logic  in_rdy;
    act_t  act;
    cond_t cond;
    step_t tgt;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic take;
    act_t act;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic   slot_free;
    logic   carve_more;
    route_t route;
  } flags_t;

  // control store
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      S_IDLE:     w = '{in_rdy: 1'b1, act: ACT_NOP,    cond: C_INPUT,  tgt: S_DISPATCH};
      S_DISPATCH: w = '{in_rdy: 1'b0, act: ACT_DECODE, cond: C_DECODE, tgt: S_EMIT};
      S_POP:      w = '{in_rdy: 1'b0, act: ACT_POP,    cond: C_GOTO,   tgt: S_EMIT};
      S_CARVE:    w = '{in_rdy: 1'b0, act: ACT_CSTEP,  cond: C_CARVE,  tgt: S_CDONE};
      S_CDONE:    w = '{in_rdy: 1'b0, act: ACT_CDONE,  cond: C_GOTO,   tgt: S_EMIT};
      S_EMIT:     w = '{in_rdy: 1'b1, act: ACT_EMIT,   cond: C_OUTPUT, tgt: S_IDLE};
      default:    w = '{in_rdy: 1'b0, act: ACT_NOP,    cond: C_GOTO,   tgt: S_IDLE};
    endcase
    return w;
  endfunction

  // block size of each class in 16 byte granules
  function automatic logic [5:0] class_granules(input logic [3:0] k);
    logic [5:0] g;
    case (k)
      4'd0:    g = 6'd1;
      4'd1:    g = 6'd2;
      4'd2:    g = 6'd4;
      4'd3:    g = 6'd6;
      4'd4:    g = 6'd8;
      4'd5:    g = 6'd10;
      4'd6:    g = 6'd12;
      4'd7:    g = 6'd14;
      4'd8:    g = 6'd16;
      4'd9:    g = 6'd20;
      4'd10:   g = 6'd24;
      4'd11:   g = 6'd28;
      4'd12:   g = 6'd32;
      4'd13:   g = 6'd40;
      default: g = 6'd0;
    endcase
    return g;
  endfunction

endpackage

[rtl/core/scba_req_if.sv]
// ----------------------------------------------------------------------------
// scba_req_if
// Request channel: operation, size and address with valid/ready.
// ----------------------------------------------------------------------------
interface scba_req_if;
  logic             valid;
  logic             ready;
  scba_pkg::op_t    op;
  scba_pkg::size_t  size;
  scba_pkg::addr_t  address;

  modport source(output valid, output op, output size, output address, input ready);
  modport sink(input valid, input op, input size, input address, output ready);
endinterface

[rtl/core/scba_res_if.sv]
// ----------------------------------------------------------------------------
// scba_res_if
// Result channel: allocated address and status with valid/ready.
// ----------------------------------------------------------------------------
interface scba_res_if;
  logic             valid;
  logic             ready;
  scba_pkg::addr_t  address_res;
  scba_pkg::stat_t  status;

  modport source(output valid, output address_res, output status, input ready);
  modport sink(input valid, input address_res, input status, output ready);
endinterface

[rtl/core/scba_seq.sv]
// ----------------------------------------------------------------------------
// scba_seq
// Step counter and control store lookup with conditional jumps.
// ----------------------------------------------------------------------------
module scba_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scba_pkg::flags_t  flags,
  output scba_pkg::ctrl_t   cw
);

  scba_pkg::step_t  step_r;
  scba_pkg::step_t  step_nxt;
  scba_pkg::uword_t uw;
  logic             take;

  // current control word
  assign uw       = scba_pkg::ucode(step_r);
  assign in_ready = uw.in_rdy && ((uw.cond != scba_pkg::C_OUTPUT) || flags.slot_free);
  assign take     = in_ready && in_valid;
  assign cw.take  = take;
  assign cw.act   = uw.act;

  // next step selection
  always_comb begin
    step_nxt = step_r;
    unique case (uw.cond)
      scba_pkg::C_INPUT: begin
        if (take) step_nxt = uw.tgt;
      end
      scba_pkg::C_DECODE: begin
        case (flags.route)
          scba_pkg::RT_POP:   step_nxt = scba_pkg::S_POP;
          scba_pkg::RT_CARVE: step_nxt = scba_pkg::S_CARVE;
          default:            step_nxt = uw.tgt;
        endcase
      end
      scba_pkg::C_GOTO: begin
        step_nxt = uw.tgt;
      end
      scba_pkg::C_CARVE: begin
        if (!flags.carve_more) step_nxt = uw.tgt;
      end
      scba_pkg::C_OUTPUT: begin
        if (flags.slot_free) step_nxt = take ? scba_pkg::S_DISPATCH : uw.tgt;
      end
      default: begin
        step_nxt = scba_pkg::S_IDLE;
      end
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= scba_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // a taken transaction is always decoded next
  a_take_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> step_r == scba_pkg::S_DISPATCH)
    else $error("taken request not followed by dispatch");

endmodule

[rtl/core/scba_dp.sv]
// ----------------------------------------------------------------------------
// scba_dp
// Allocator datapath: request decode, class list heads, link memory,
// chunk carving registers and the result register.
// ----------------------------------------------------------------------------
module scba_dp #(
  parameter int CHUNK_BYTES   = scba_pkg::DEF_CHUNK_BYTES,
  parameter int MAX_CHUNKS    = scba_pkg::DEF_MAX_CHUNKS,
  parameter int LARGEST_CLASS = scba_pkg::DEF_LARGEST_CLASS,
  parameter int CLASS_COUNT   = scba_pkg::DEF_CLASS_COUNT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scba_pkg::ctrl_t   cw,
  output scba_pkg::flags_t  flags,
  input  scba_pkg::op_t     req_op,
  input  scba_pkg::size_t   req_size,
  input  scba_pkg::addr_t   req_address,
  output logic              out_valid,
  input  logic              out_ready,
  output scba_pkg::addr_t   out_address_res,
  output scba_pkg::stat_t   out_status
);

  localparam int NCLS     = (CLASS_COUNT < scba_pkg::TABLE_LEN) ? CLASS_COUNT
                                                                 : scba_pkg::TABLE_LEN;
  localparam int CLW      = (NCLS > 1) ? $clog2(NCLS) : 1;
  localparam int CHUNK_G  = CHUNK_BYTES / 16;
  localparam int GRANULES = CHUNK_G * MAX_CHUNKS;
  localparam int GW       = $clog2(GRANULES);
  localparam int LW       = GW + 1;
  localparam int OFW      = $clog2(CHUNK_G + 1);
  localparam int OSW      = OFW + 2;
  localparam int CUW      = $clog2(MAX_CHUNKS + 1);
  localparam logic [31:0] POOL_B = 32'(CHUNK_BYTES * MAX_CHUNKS);

  // request registers
  scba_pkg::op_t    req_op_r;
  scba_pkg::size_t  req_size_r;
  scba_pkg::addr_t  req_addr_r;

  // class list heads
  logic [NCLS-1:0]  head_vld_r;
  logic [GW-1:0]    head_idx_r [NCLS];

  // link memory
  logic [LW-1:0]    link_mem [GRANULES];
  logic [LW-1:0]    link_rd_r;
  logic             mem_we;
  logic [GW-1:0]    mem_waddr;
  logic [LW-1:0]    mem_wdata;
  logic             mem_re;

  // carving and bookkeeping
  logic [CUW-1:0]   chunks_used_r;
  logic [CLW-1:0]   cls_r;
  logic [GW-1:0]    base_r;
  logic [GW-1:0]    here_r;
  logic [OFW-1:0]   off_r;
  logic [5:0]       bs_r;

  // pending and output result
  scba_pkg::addr_t  pend_addr_r;
  scba_pkg::stat_t  pend_status_r;
  scba_pkg::addr_t  out_addr_r;
  scba_pkg::stat_t  out_status_r;
  logic             out_valid_r;
  logic             slot_free;

  // decode signals
  logic             cls_hit;
  logic [CLW-1:0]   cls_idx;
  logic             head_v;
  logic [GW-1:0]    head_g;
  logic             size_zero;
  logic             oversize;
  logic             sized_op;
  logic             in_pool;
  logic [GW-1:0]    free_g;
  logic             head_in;
  logic             carve_ok;
  logic [GW-1:0]    base_g;
  logic             free_go;
  logic             pop_go;
  logic             pop_bad;
  logic             carve_go;
  scba_pkg::stat_t  dec_status;
  scba_pkg::addr_t  dec_addr;
  scba_pkg::route_t route;

  // carve step signals
  logic [OSW-1:0]   off_sum;
  logic             carve_more;
  logic             two_fit;
  logic [GW-1:0]    here_next;
  logic [GW-1:0]    base_next;

  // size class lookup, smallest fitting class wins
  always_comb begin
    cls_hit = 1'b0;
    cls_idx = '0;
    for (int k = NCLS - 1; k >= 0; k--) begin
      if ({6'd0, scba_pkg::class_granules(4'(k)), 4'd0} >= req_size_r) begin
        cls_hit = 1'b1;
        cls_idx = CLW'(k);
      end
    end
  end

  // request decode
  always_comb begin
    head_v    = head_vld_r[cls_idx];
    head_g    = head_idx_r[cls_idx];
    size_zero = (req_size_r == '0);
    oversize  = (req_size_r > scba_pkg::size_t'(LARGEST_CLASS)) || !cls_hit;
    sized_op  = ((req_op_r == scba_pkg::OP_ALLOC) || (req_op_r == scba_pkg::OP_FREE))
                && !size_zero && !oversize;
    in_pool   = ({14'd0, req_addr_r} < POOL_B);
    free_g    = GW'({18'd0, req_addr_r[17:4]});
    head_in   = (32'(head_g) < 32'(GRANULES));
    carve_ok  = (chunks_used_r < CUW'(MAX_CHUNKS));
    base_g    = GW'(32'(chunks_used_r) * 32'(CHUNK_G));

    free_go   = sized_op && (req_op_r == scba_pkg::OP_FREE) && in_pool;
    pop_go    = sized_op && (req_op_r == scba_pkg::OP_ALLOC) && head_v && head_in;
    pop_bad   = sized_op && (req_op_r == scba_pkg::OP_ALLOC) && head_v && !head_in;
    carve_go  = sized_op && (req_op_r == scba_pkg::OP_ALLOC) && !head_v && carve_ok;

    if (pop_go) begin
      route = scba_pkg::RT_POP;
    end else if (carve_go) begin
      route = scba_pkg::RT_CARVE;
    end else begin
      route = scba_pkg::RT_DONE;
    end

    if ((req_op_r != scba_pkg::OP_ALLOC) && (req_op_r != scba_pkg::OP_FREE)) begin
      dec_status = scba_pkg::ST_OK;
    end else if (size_zero) begin
      dec_status = scba_pkg::ST_ZERO;
    end else if (oversize) begin
      dec_status = scba_pkg::ST_OVERSIZE;
    end else if (req_op_r == scba_pkg::OP_FREE) begin
      dec_status = scba_pkg::ST_OK;
    end else if (head_v) begin
      dec_status = head_in ? scba_pkg::ST_OK : scba_pkg::ST_EXHAUSTED;
    end else begin
      dec_status = carve_ok ? scba_pkg::ST_OK : scba_pkg::ST_EXHAUSTED;
    end

    if (pop_go) begin
      dec_addr = scba_pkg::addr_t'({head_g, 4'd0});
    end else if (carve_go) begin
      dec_addr = scba_pkg::addr_t'({base_g, 4'd0});
    end else begin
      dec_addr = '0;
    end
  end

  // carve step: link the block at here_r to the next one while one fits
  always_comb begin
    off_sum    = OSW'(off_r) + OSW'({bs_r, 1'b0});
    carve_more = (off_sum <= OSW'(CHUNK_G));
    two_fit    = (OSW'({bs_r, 1'b0}) <= OSW'(CHUNK_G));
    here_next  = GW'(32'(here_r) + 32'(bs_r));
    base_next  = GW'(32'(base_r) + 32'(bs_r));
  end

  assign slot_free        = !out_valid_r || out_ready;
  assign flags.slot_free  = slot_free;
  assign flags.carve_more = carve_more;
  assign flags.route      = route;

  // link memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_g;
    mem_wdata = {head_v, head_g};
    mem_re    = (cw.act == scba_pkg::ACT_DECODE) && pop_go;
    if ((cw.act == scba_pkg::ACT_DECODE) && free_go) begin
      mem_we = 1'b1;
    end else if (cw.act == scba_pkg::ACT_CSTEP) begin
      mem_we    = 1'b1;
      mem_waddr = here_r;
      mem_wdata = carve_more ? {1'b1, here_next} : '0;
    end
  end

  // link memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      link_rd_r <= link_mem[head_g];
    end
  end

  // control state: list valid bits, chunk count, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r    <= '0;
      chunks_used_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      case (cw.act)
        scba_pkg::ACT_DECODE: begin
          if (req_op_r == scba_pkg::OP_CLEAR) begin
            head_vld_r    <= '0;
            chunks_used_r <= '0;
          end else if (free_go) begin
            head_vld_r[cls_idx] <= 1'b1;
          end else if (pop_bad) begin
            head_vld_r[cls_idx] <= 1'b0;
          end
        end
        scba_pkg::ACT_POP: begin
          head_vld_r[cls_r] <= link_rd_r[LW-1];
        end
        scba_pkg::ACT_CDONE: begin
          head_vld_r[cls_r] <= two_fit;
          chunks_used_r     <= chunks_used_r + 1'b1;
        end
        default: ;
      endcase
      if ((cw.act == scba_pkg::ACT_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cw.take) begin
      req_op_r   <= req_op;
      req_size_r <= req_size;
      req_addr_r <= req_address;
    end
    case (cw.act)
      scba_pkg::ACT_DECODE: begin
        cls_r         <= cls_idx;
        pend_status_r <= dec_status;
        pend_addr_r   <= dec_addr;
        base_r        <= base_g;
        here_r        <= base_g;
        off_r         <= '0;
        bs_r          <= scba_pkg::class_granules(4'(cls_idx));
        if (free_go) begin
          head_idx_r[cls_idx] <= free_g;
        end
      end
      scba_pkg::ACT_POP: begin
        head_idx_r[cls_r] <= link_rd_r[GW-1:0];
      end
      scba_pkg::ACT_CSTEP: begin
        if (carve_more) begin
          here_r <= here_next;
          off_r  <= OFW'(32'(off_r) + 32'(bs_r));
        end
      end
      scba_pkg::ACT_CDONE: begin
        head_idx_r[cls_r] <= base_next;
      end
      scba_pkg::ACT_EMIT: begin
        if (slot_free) begin
          out_addr_r   <= pend_addr_r;
          out_status_r <= pend_status_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_address_res = out_addr_r;
  assign out_status      = out_status_r;

  // chunk count never passes the pool size
  a_chunks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chunks_used_r <= CUW'(MAX_CHUNKS))
    else $error("chunk count beyond pool");

  // a failed request never carries an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != scba_pkg::ST_OK)) |-> (out_addr_r == '0))
    else $error("nonzero address with error status");

  // every linked block starts inside the chunk being carved
  a_carve_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.act == scba_pkg::ACT_CSTEP) |-> (32'(off_r) < 32'(CHUNK_G)))
    else $error("carve offset outside chunk");

  // a pop consumes a link read issued in the previous cycle
  a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.act == scba_pkg::ACT_POP) |-> $past(mem_re))
    else $error("pop without link read");

endmodule

[rtl/core/size_class_block_allocator.sv]
// Segregated free-list allocator for small blocks out of a pool of
// MAX_CHUNKS chunks of CHUNK_BYTES bytes, in up to 14 size classes from
// 16 to 640 bytes. Every request transaction gives exactly one result
// transaction. A free, a clear, and any request rejected for size zero,
// oversize or pool exhaustion goes from the dispatch step straight to the
// emit step; an allocate served from a class list adds a pop step after
// one registered read of the link memory. An allocate that carves a fresh
// chunk loops in the carve step before the carve-done step, since the new
// list is threaded through the link memory's single write port one block
// per cycle. A new request is accepted while the previous result still
// waits in the output register.
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Top level: microcoded sequencer driving the allocator datapath.
// ----------------------------------------------------------------------------
module size_class_block_allocator #(
  parameter int CHUNK_BYTES   = scba_pkg::DEF_CHUNK_BYTES,
  parameter int MAX_CHUNKS    = scba_pkg::DEF_MAX_CHUNKS,
  parameter int LARGEST_CLASS = scba_pkg::DEF_LARGEST_CLASS,
  parameter int CLASS_COUNT   = scba_pkg::DEF_CLASS_COUNT
) (
  input  logic          clk,
  input  logic          rst_n,
  scba_req_if.sink      in_ch,
  scba_res_if.source    out_ch
);

  scba_pkg::ctrl_t  cw;
  scba_pkg::flags_t flags;

  // step counter and control store
  scba_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .flags    (flags),
    .cw       (cw)
  );

  // allocator datapath
  scba_dp #(
    .CHUNK_BYTES   (CHUNK_BYTES),
    .MAX_CHUNKS    (MAX_CHUNKS),
    .LARGEST_CLASS (LARGEST_CLASS),
    .CLASS_COUNT   (CLASS_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cw              (cw),
    .flags           (flags),
    .req_op          (in_ch.op),
    .req_size        (in_ch.size),
    .req_address     (in_ch.address),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_address_res (out_ch.address_res),
    .out_status      (out_ch.status)
  );

endmodule
